>>> hdl/onewire_master_slot_engine_top_macros.svh
// Assertion macros shared by the 1-Wire master slot engine RTL.
`ifndef ONEWIRE_MASTER_SLOT_ENGINE_TOP_MACROS_SVH
`define ONEWIRE_MASTER_SLOT_ENGINE_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define OWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owm assertion failed");

// Check that a condition implies another in the next cycle.
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owm assertion failed");

`endif

>>> hdl/owm_pkg.sv
// Shared types and codes of the 1-Wire master slot engine.
`default_nettype none
package owm_pkg;

  localparam int OWM_TIMER_WIDTH = 12;
  localparam int CFG_W = 12;

  // Command codes on the action field
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd1;
  localparam logic [2:0] ACT_WBYTE = 3'd2;
  localparam logic [2:0] ACT_RBYTE = 3'd3;
  localparam logic [2:0] ACT_WBIT  = 3'd4;
  localparam logic [2:0] ACT_RBIT  = 3'd5;
  localparam logic [2:0] ACT_CONV  = 3'd6;
  localparam logic [2:0] ACT_TICK2 = 3'd7;

  // Engine modes, sharing the command encoding
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_RESET = 3'd1;
  localparam logic [2:0] MODE_WBYTE = 3'd2;
  localparam logic [2:0] MODE_RBYTE = 3'd3;
  localparam logic [2:0] MODE_WBIT  = 3'd4;
  localparam logic [2:0] MODE_RBIT  = 3'd5;
  localparam logic [2:0] MODE_CONV  = 3'd6;

  // Line drive codes
  localparam logic [1:0] LINE_REL  = 2'd0;
  localparam logic [1:0] LINE_LOW  = 2'd1;
  localparam logic [1:0] LINE_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_SMP  = 3'd1;
  localparam logic [2:0] CFG_RESET_SLOT    = 3'd2;
  localparam logic [2:0] CFG_WRITE_LOW     = 3'd3;
  localparam logic [2:0] CFG_WRITE_RELEASE = 3'd4;
  localparam logic [2:0] CFG_WRITE_SLOT    = 3'd5;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] CFG_READ_SLOT     = 3'd7;

  // Fixed slot points in microseconds
  localparam int RD_PULSE  = 2;
  localparam int CV_PULSE  = 2;
  localparam int CV_SAMPLE = 12;
  localparam int CV_SLOT   = 76;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] presence_sample_time;
    logic [CFG_W-1:0] reset_slot_time;
    logic [CFG_W-1:0] write_low_time;
    logic [CFG_W-1:0] write_release_time;
    logic [CFG_W-1:0] write_slot_time;
    logic [CFG_W-1:0] read_sample_time;
    logic [CFG_W-1:0] read_slot_time;
  } owm_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic       presence_flag;
    logic       seen_high;
    logic [1:0] line_state;
    logic       release_flag;
  } owm_state_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       done_res;
    logic       presence_found;
    logic [7:0] read_data;
  } owm_res_t;

endpackage
`default_nettype wire

>>> hdl/owm_cfg_regs.sv
// Timing register file of the 1-Wire master slot engine.
`default_nettype none
module owm_cfg_regs
  import owm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [2:0]       wr_index,
  input  wire logic [CFG_W-1:0] wr_data,
  output owm_cfg_t              cfg
);

  owm_cfg_t cfg_r;
  owm_cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_RESET_LOW:     cfg_nxt.reset_low_time       = wr_data;
        CFG_PRESENCE_SMP:  cfg_nxt.presence_sample_time = wr_data;
        CFG_RESET_SLOT:    cfg_nxt.reset_slot_time      = wr_data;
        CFG_WRITE_LOW:     cfg_nxt.write_low_time       = wr_data;
        CFG_WRITE_RELEASE: cfg_nxt.write_release_time   = wr_data;
        CFG_WRITE_SLOT:    cfg_nxt.write_slot_time      = wr_data;
        CFG_READ_SAMPLE:   cfg_nxt.read_sample_time     = wr_data;
        CFG_READ_SLOT:     cfg_nxt.read_slot_time       = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Load defaults at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time       <= CFG_W'(550);
      cfg_r.presence_sample_time <= CFG_W'(630);
      cfg_r.reset_slot_time      <= CFG_W'(2180);
      cfg_r.write_low_time       <= CFG_W'(3);
      cfg_r.write_release_time   <= CFG_W'(60);
      cfg_r.write_slot_time      <= CFG_W'(164);
      cfg_r.read_sample_time     <= CFG_W'(16);
      cfg_r.read_slot_time       <= CFG_W'(166);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hdl/owm_slot_step.sv
// Next-state and result logic for one item of the slot engine.
`default_nettype none
module owm_slot_step
  import owm_pkg::*;
#(
  parameter int TIMER_WIDTH = OWM_TIMER_WIDTH
) (
  input  wire owm_cfg_t          cfg,
  input  wire owm_state_t        st,
  input  wire logic [TIMER_WIDTH-1:0] tmr,
  input  wire logic [2:0]        action,
  input  wire logic [7:0]        write_data,
  input  wire logic              release_at_end,
  input  wire logic              line_sense,
  output owm_state_t             st_nxt,
  output logic [TIMER_WIDTH-1:0] tmr_nxt,
  output owm_res_t               res
);

  // Fit a register value to the timer width (modulo 2^TIMER_WIDTH)
  function automatic logic [TIMER_WIDTH-1:0] fit(input logic [CFG_W-1:0] v);
    logic [TIMER_WIDTH+CFG_W-1:0] ext;
    ext = {{TIMER_WIDTH{1'b0}}, v};
    return ext[TIMER_WIDTH-1:0];
  endfunction

  localparam logic [TIMER_WIDTH-1:0] T_RD_PULSE  = TIMER_WIDTH'(RD_PULSE);
  localparam logic [TIMER_WIDTH-1:0] T_CV_PULSE  = TIMER_WIDTH'(CV_PULSE);
  localparam logic [TIMER_WIDTH-1:0] T_CV_SAMPLE = TIMER_WIDTH'(CV_SAMPLE);
  localparam logic [TIMER_WIDTH-1:0] T_CV_SLOT   = TIMER_WIDTH'(CV_SLOT);

  logic [TIMER_WIDTH-1:0] t_inc;
  logic                   cur_bit;
  logic                   is_tick;
  logic                   done;
  logic [7:0]             rdata;

  assign t_inc   = (tmr == {TIMER_WIDTH{1'b1}}) ? tmr : tmr + 1'b1;
  assign cur_bit = st.shift_byte[st.bit_index];
  assign is_tick = (action == ACT_TICK) || (action == ACT_TICK2);

  always_comb begin
    st_nxt  = st;
    tmr_nxt = tmr;
    done    = 1'b0;
    rdata   = 8'd0;
    if (st.mode == MODE_IDLE || st.mode > MODE_CONV) begin
      // Start a command from idle; an out-of-range mode returns to idle
      st_nxt.mode = MODE_IDLE;
      if (action inside {[ACT_RESET:ACT_CONV]}) begin
        st_nxt.mode         = action;
        tmr_nxt             = '0;
        st_nxt.bit_index    = 3'd0;
        st_nxt.line_state   = LINE_LOW;
        st_nxt.release_flag = release_at_end;
        st_nxt.seen_high    = 1'b0;
        if (action == ACT_RESET) st_nxt.presence_flag = 1'b0;
        if (action == ACT_WBYTE) st_nxt.shift_byte = write_data;
        else if (action == ACT_WBIT) st_nxt.shift_byte = {7'd0, write_data[0]};
        else st_nxt.shift_byte = 8'd0;
      end
    end else if (is_tick) begin
      // Advance the slot timer and act on the slot points
      tmr_nxt = t_inc;
      case (st.mode)
        MODE_RESET: begin
          if (t_inc == fit(cfg.reset_low_time)) st_nxt.line_state = LINE_REL;
          if (t_inc == fit(cfg.presence_sample_time) && !line_sense)
            st_nxt.presence_flag = 1'b1;
          if (t_inc >= fit(cfg.reset_slot_time)) begin
            st_nxt.mode = MODE_IDLE;
            done        = 1'b1;
          end
        end
        MODE_WBYTE, MODE_WBIT: begin
          if (t_inc == fit(cfg.write_low_time) && cur_bit) st_nxt.line_state = LINE_HIGH;
          if (t_inc == fit(cfg.write_release_time)) st_nxt.line_state = LINE_HIGH;
          if (t_inc >= fit(cfg.write_slot_time)) begin
            if (st.mode == MODE_WBIT || st.bit_index == 3'd7) begin
              st_nxt.mode       = MODE_IDLE;
              done              = 1'b1;
              st_nxt.line_state = st.release_flag ? LINE_REL : LINE_HIGH;
            end else begin
              st_nxt.bit_index  = st.bit_index + 3'd1;
              tmr_nxt           = '0;
              st_nxt.line_state = LINE_LOW;
            end
          end
        end
        MODE_RBYTE, MODE_RBIT: begin
          if (t_inc == T_RD_PULSE) st_nxt.line_state = LINE_REL;
          if (t_inc == fit(cfg.read_sample_time) && line_sense)
            st_nxt.shift_byte[st.bit_index] = 1'b1;
          if (t_inc >= fit(cfg.read_slot_time)) begin
            if (st.mode == MODE_RBIT || st.bit_index == 3'd7) begin
              st_nxt.mode = MODE_IDLE;
              done        = 1'b1;
              rdata       = st_nxt.shift_byte;
            end else begin
              st_nxt.bit_index  = st.bit_index + 3'd1;
              tmr_nxt           = '0;
              st_nxt.line_state = LINE_LOW;
            end
          end
        end
        default: begin
          // Conversion wait: short read slots until a high sample
          if (t_inc == T_CV_PULSE) st_nxt.line_state = LINE_REL;
          if (t_inc == T_CV_SAMPLE && line_sense) st_nxt.seen_high = 1'b1;
          if (t_inc >= T_CV_SLOT) begin
            if (st_nxt.seen_high) begin
              st_nxt.mode = MODE_IDLE;
              done        = 1'b1;
            end else begin
              tmr_nxt           = '0;
              st_nxt.line_state = LINE_LOW;
            end
          end
        end
      endcase
    end
  end

  // Assemble the result item
  always_comb begin
    res.line_drive     = st_nxt.line_state;
    res.busy_res       = (st_nxt.mode != MODE_IDLE);
    res.done_res       = done;
    res.presence_found = st_nxt.presence_flag;
    res.read_data      = rdata;
  end

endmodule
`default_nettype wire

>>> hdl/owm_out_stage.sv
// Result register with valid/ready handshake for the slot engine.
`default_nettype none
module owm_out_stage
  import owm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire owm_res_t res_in,
  input  wire logic     out_ready,
  output logic          out_valid,
  output logic          can_load,
  output owm_res_t      res_out
);

  logic     valid_r;
  logic     valid_nxt;
  owm_res_t res_r;

  // Take a new item when empty or when the held one leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule
`default_nettype wire

>>> hdl/onewire_master_slot_engine_top.sv
// Top level of the 1-Wire bus master slot engine.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | action, write_data, release_at_end, line_sense
//  out_    | output    | out_valid/out_ready | line_drive, busy/done, presence_found, read_data
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index (3 b), cfg_data (12 b)
//
// The state registers and the result register load on the same edge the item is
// accepted, so one item per cycle is sustained unless a held result drops in_ready.
// Synchronous active-low reset idles the engine and loads the timing defaults.
// in_ready drops only while a result is held and out_ready is low.
// Configuration writes are always ready and take effect on the next item.
`default_nettype none
`include "onewire_master_slot_engine_top_macros.svh"
module onewire_master_slot_engine_top
  import owm_pkg::*;
#(
  parameter int TIMER_WIDTH = OWM_TIMER_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_action,
  input  wire logic [7:0]       in_write_data,
  input  wire logic             in_release_at_end,
  input  wire logic             in_line_sense,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_line_drive,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic                  out_presence_found,
  output logic [7:0]            out_read_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  owm_cfg_t               cfg;
  owm_state_t             st_r;
  owm_state_t             st_nxt;
  logic [TIMER_WIDTH-1:0] tmr_r;
  logic [TIMER_WIDTH-1:0] tmr_nxt;
  owm_res_t               res;
  owm_res_t               res_q;
  logic                   can_load;
  logic                   in_fire;
  logic                   cmd_start;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign in_fire   = in_valid && can_load;

  // Flag a command item taken while the engine is idle
  assign cmd_start = in_fire && (st_r.mode == MODE_IDLE) &&
                     (in_action != ACT_TICK) && (in_action != ACT_TICK2);

  owm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owm_slot_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .cfg            (cfg),
    .st             (st_r),
    .tmr            (tmr_r),
    .action         (in_action),
    .write_data     (in_write_data),
    .release_at_end (in_release_at_end),
    .line_sense     (in_line_sense),
    .st_nxt         (st_nxt),
    .tmr_nxt        (tmr_nxt),
    .res            (res)
  );

  // Advance engine state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode          <= MODE_IDLE;
      st_r.bit_index     <= 3'd0;
      st_r.shift_byte    <= 8'd0;
      st_r.presence_flag <= 1'b0;
      st_r.seen_high     <= 1'b0;
      st_r.line_state    <= LINE_REL;
      st_r.release_flag  <= 1'b0;
      tmr_r              <= '0;
    end else if (in_fire) begin
      st_r  <= st_nxt;
      tmr_r <= tmr_nxt;
    end
  end

  owm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  assign out_line_drive     = res_q.line_drive;
  assign out_busy_res       = res_q.busy_res;
  assign out_done_res       = res_q.done_res;
  assign out_presence_found = res_q.presence_found;
  assign out_read_data      = res_q.read_data;

  // A finished command never reports busy
  `OWM_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid && out_done_res, !out_busy_res)
  // Read data shows only on a done item
  `OWM_ASSERT_NOW(a_rdata_on_done, clk, rst_n, out_valid && (out_read_data != 8'd0), out_done_res)
  // A command accepted while idle starts the engine with a cleared timer
  `OWM_ASSERT_NEXT(a_cmd_starts, clk, rst_n, cmd_start, (st_r.mode != MODE_IDLE) && (tmr_r == '0))

endmodule
`default_nettype wire
